>>> rtl/ikt_pkg.sv
// Shared types and constants for the inflight kernel timeout tracker.
package ikt_pkg;

    localparam int unsigned MAX_SLOTS_DEF = 16;
    localparam int unsigned KERNEL_UNITS = 16;
    localparam logic [31:0] DEFAULT_TIMEOUT_RST = 32'd10000000;

    // request modes
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_POLL   = 1'b1;

    // slot flag bit positions
    localparam int unsigned FLAG_INF = 0;
    localparam int unsigned FLAG_HALT = 1;
    localparam int unsigned FLAG_SILENT = 2;

    typedef enum logic [2:0] {
        KIND_ACCEPTED  = 3'd0,
        KIND_FULL      = 3'd1,
        KIND_COMPLETED = 3'd2,
        KIND_TIMED_OUT = 3'd3,
        KIND_PASS_END  = 3'd4,
        KIND_HALTED    = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_VISIT,
        ST_EXAM,
        ST_COPY,
        ST_HALT_MSG
    } state_t;

    typedef struct packed {
        logic [9:0]  node;
        logic [3:0]  unit;
        logic [7:0]  bucket;
        logic [31:0] mask;
        logic [31:0] remaining;
        logic [2:0]  flags;
    } slot_t;

    localparam int unsigned SLOT_W = $bits(slot_t);

endpackage

>>> rtl/ikt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ikt_ram
    import ikt_pkg::*;
#(
    parameter int unsigned WIDTH = SLOT_W,
    parameter int unsigned DEPTH = MAX_SLOTS_DEF,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/inflight_kernel_timeout_tracker_unit.sv
// Top level of the inflight kernel timeout tracker: slot table and pass sequencer.
//
// An item is taken when start is high and busy is low. Insert, full and halted
// replies appear in the next cycle as a single result. A poll pass walks the
// slot table through the one read port of the slot RAM: each slot is read and
// examined, and a kept slot has its decremented countdown written back; a
// retired slot that is not the last one has the last slot read and copied into
// its position, and a closing check ends the pass with a pass-end result. A
// halting timeout ends the pass early and is followed by the halted result.
// Every result is shown for exactly one cycle with strobe high; the receiver
// cannot stall, so results must be taken as they come. busy drops in the
// cycle the last result of the item is shown.
module inflight_kernel_timeout_tracker_unit
    import ikt_pkg::*;
#(
    parameter int unsigned MAX_SLOTS = MAX_SLOTS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        mode,
    input  logic [9:0]  node_id,
    input  logic [3:0]  kernel_unit,
    input  logic [7:0]  barrier_bucket,
    input  logic [31:0] barrier_mask,
    input  logic [31:0] timeout_passes,
    input  logic        infinite,
    input  logic        halt_on_timeout,
    input  logic        silent,
    input  logic [15:0] done_vector,
    output logic        strobe,
    output logic [2:0]  kind,
    output logic [9:0]  node_out,
    output logic [7:0]  bucket_out,
    output logic [31:0] mask_out,
    output logic        raise_barrier,
    output logic        report,
    output logic        progress,
    output logic        last
);

    localparam int unsigned IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int unsigned CNT_W = $clog2(MAX_SLOTS + 1);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              halted_reg, halted_next;
    logic              prog_reg, prog_next;
    logic [15:0]       dvec_reg, dvec_next;
    logic [31:0]       dflt_reg, dflt_next;

    logic              strobe_reg, strobe_next;
    kind_t             kind_reg, kind_next;
    logic [9:0]        node_reg, node_next;
    logic [7:0]        bucket_reg, bucket_next;
    logic [31:0]       mask_reg, mask_next;
    logic              raise_reg, raise_next;
    logic              report_reg, report_next;
    logic              progress_reg, progress_next;
    logic              last_reg, last_next;

    logic              ram_we, ram_re;
    logic [IDX_W-1:0]  ram_waddr, ram_raddr;
    logic [SLOT_W-1:0] ram_rdata;
    slot_t             ram_wslot, cur;
    logic [CNT_W-1:0]  cnt_dec;
    logic [31:0]       rem_dec;
    logic              unit_done;

    ikt_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (MAX_SLOTS)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wslot),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cur       = slot_t'(ram_rdata);
    assign cnt_dec   = count_reg - CNT_W'(1);
    // shared countdown unit
    assign rem_dec   = cur.remaining - 32'd1;
    assign unit_done = (32'(cur.unit) < KERNEL_UNITS) && dvec_reg[cur.unit];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            idx_reg    <= '0;
            halted_reg <= 1'b0;
            prog_reg   <= 1'b0;
            dflt_reg   <= DEFAULT_TIMEOUT_RST;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            halted_reg <= halted_next;
            prog_reg   <= prog_next;
            dflt_reg   <= dflt_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvec_reg     <= dvec_next;
        kind_reg     <= kind_next;
        node_reg     <= node_next;
        bucket_reg   <= bucket_next;
        mask_reg     <= mask_next;
        raise_reg    <= raise_next;
        report_reg   <= report_next;
        progress_reg <= progress_next;
        last_reg     <= last_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        halted_next   = halted_reg;
        prog_next     = prog_reg;
        dvec_next     = dvec_reg;
        dflt_next     = cfg_we ? cfg_wdata : dflt_reg;
        strobe_next   = 1'b0;
        kind_next     = kind_reg;
        node_next     = node_reg;
        bucket_next   = bucket_reg;
        mask_next     = mask_reg;
        raise_next    = raise_reg;
        report_next   = report_reg;
        progress_next = progress_reg;
        last_next     = last_reg;
        ram_we        = 1'b0;
        ram_waddr     = idx_reg[IDX_W-1:0];
        ram_wslot     = cur;
        ram_re        = 1'b0;
        ram_raddr     = idx_reg[IDX_W-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    strobe_next   = 1'b1;
                    node_next     = node_id;
                    bucket_next   = '0;
                    mask_next     = '0;
                    raise_next    = 1'b0;
                    report_next   = 1'b0;
                    progress_next = 1'b0;
                    last_next     = 1'b1;
                    if (halted_reg)
                    begin
                        kind_next = KIND_HALTED;
                        node_next = '0;
                    end
                    else if (mode == MODE_INSERT)
                    begin
                        if (32'(count_reg) >= MAX_SLOTS)
                        begin
                            kind_next = KIND_FULL;
                        end
                        else
                        begin
                            kind_next           = KIND_ACCEPTED;
                            ram_we              = 1'b1;
                            ram_waddr           = count_reg[IDX_W-1:0];
                            ram_wslot.node      = node_id;
                            ram_wslot.unit      = kernel_unit;
                            ram_wslot.bucket    = barrier_bucket;
                            ram_wslot.mask      = barrier_mask;
                            ram_wslot.remaining = (timeout_passes == 32'd0) ? dflt_reg
                                                                             : timeout_passes;
                            ram_wslot.flags     = {silent, halt_on_timeout, infinite};
                            count_next          = count_reg + CNT_W'(1);
                        end
                    end
                    else
                    begin
                        strobe_next = 1'b0;
                        dvec_next   = done_vector;
                        idx_next    = '0;
                        prog_next   = 1'b0;
                        state_next  = ST_VISIT;
                    end
                end
            end

            ST_VISIT:
            begin
                if (idx_reg >= count_reg)
                begin
                    strobe_next   = 1'b1;
                    kind_next     = KIND_PASS_END;
                    node_next     = '0;
                    bucket_next   = '0;
                    mask_next     = '0;
                    raise_next    = 1'b0;
                    report_next   = 1'b0;
                    progress_next = prog_reg;
                    last_next     = 1'b1;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    ram_re     = 1'b1;
                    state_next = ST_EXAM;
                end
            end

            ST_EXAM:
            begin
                node_next     = cur.node;
                bucket_next   = cur.bucket;
                mask_next     = cur.mask;
                progress_next = 1'b0;
                last_next     = 1'b0;
                if (unit_done || rem_dec == 32'd0)
                begin
                    strobe_next = 1'b1;
                    count_next  = cnt_dec;
                    if (unit_done)
                    begin
                        kind_next   = KIND_COMPLETED;
                        raise_next  = !cur.flags[FLAG_INF];
                        report_next = !cur.flags[FLAG_INF] && !cur.flags[FLAG_SILENT];
                    end
                    else
                    begin
                        kind_next   = KIND_TIMED_OUT;
                        raise_next  = !cur.flags[FLAG_HALT];
                        report_next = !cur.flags[FLAG_SILENT];
                    end
                    if (!unit_done && cur.flags[FLAG_HALT])
                    begin
                        // rest of the table is never looked at again
                        halted_next = 1'b1;
                        state_next  = ST_HALT_MSG;
                    end
                    else
                    begin
                        prog_next = 1'b1;
                        if (idx_reg < cnt_dec)
                        begin
                            // fetch the last slot to move into this position
                            ram_re     = 1'b1;
                            ram_raddr  = cnt_dec[IDX_W-1:0];
                            state_next = ST_COPY;
                        end
                        else
                        begin
                            state_next = ST_VISIT;
                        end
                    end
                end
                else
                begin
                    ram_we              = 1'b1;
                    ram_wslot.remaining = rem_dec;
                    idx_next            = idx_reg + CNT_W'(1);
                    state_next          = ST_VISIT;
                end
            end

            ST_COPY:
            begin
                ram_we     = 1'b1;
                state_next = ST_VISIT;
            end

            ST_HALT_MSG:
            begin
                strobe_next   = 1'b1;
                kind_next     = KIND_HALTED;
                node_next     = '0;
                bucket_next   = '0;
                mask_next     = '0;
                raise_next    = 1'b0;
                report_next   = 1'b0;
                progress_next = 1'b0;
                last_next     = 1'b1;
                state_next    = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy          = (state_reg != ST_IDLE);
    assign strobe        = strobe_reg;
    assign kind          = kind_reg;
    assign node_out      = node_reg;
    assign bucket_out    = bucket_reg;
    assign mask_out      = mask_reg;
    assign raise_barrier = raise_reg;
    assign report        = report_reg;
    assign progress      = progress_reg;
    assign last          = last_reg;

endmodule
